/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* rtl/gbp_pkg.sv */
// ----------------------------------------------------------------------------
// gbp_pkg
// Types and constants shared by the gshare branch predictor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gbp_pkg;

    localparam int ADDR_W = 64;
    localparam int CTR_W  = 2;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] HASH_XOR_SHIFT = 2'd0;
    localparam logic [MODE_W-1:0] HASH_XOR_RAW   = 2'd1;
    localparam logic [MODE_W-1:0] HASH_ADD_SHIFT = 2'd2;

    localparam logic [CTR_W-1:0] CTR_MIN     = 2'd0;
    localparam logic [CTR_W-1:0] CTR_WEAK_NT = 2'd1;
    localparam logic [CTR_W-1:0] CTR_MAX     = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

`default_nettype wire

/* rtl/gbp_ram.sv */
// ----------------------------------------------------------------------------
// gbp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/gbp_index.sv */
// ----------------------------------------------------------------------------
// gbp_index
// Forms the table index from the branch address and the global history.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_index #(
    parameter int INDEX_BITS = 12
) (
    input  wire logic [gbp_pkg::MODE_W-1:0] i_mode,
    input  wire logic [INDEX_BITS+1:0]      i_addr_low,
    input  wire logic [INDEX_BITS-1:0]      i_history,
    output logic      [INDEX_BITS-1:0]      o_index
);

    logic [INDEX_BITS-1:0] addr_shift;
    logic [INDEX_BITS-1:0] addr_raw;

    assign addr_shift = i_addr_low[INDEX_BITS+1:2];
    assign addr_raw   = i_addr_low[INDEX_BITS-1:0];

    // The unused mode code behaves as the add hash.
    always_comb begin
        case (i_mode)
            gbp_pkg::HASH_XOR_SHIFT: o_index = addr_shift ^ i_history;
            gbp_pkg::HASH_XOR_RAW:   o_index = addr_raw ^ i_history;
            default:                 o_index = addr_shift + i_history;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/gshare_branch_predictor.sv */
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// An accepted item moves from idle to the lookup state, where its result is
// registered. No new item is accepted until its table entry has been read
// and written back in the single table RAM, nor while a result is stalled.
// After reset every table entry is cleared, during which no item is
// accepted.
`default_nettype none
`include "assert_macros.svh"

module gshare_branch_predictor #(
    parameter int INDEX_BITS = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gbp_pkg::MODE_W-1:0]     i_cfg_wdata,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [gbp_pkg::ADDR_W-1:0]     i_branch_address,
    input  wire logic                           i_actual_taken,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_predicted_taken,
    output logic                                o_tag_conflict
);

    localparam int DEPTH  = 2 ** INDEX_BITS;
    localparam int ENTRY_W = gbp_pkg::ADDR_W + gbp_pkg::CTR_W;

    gbp_pkg::t_state r_state;
    gbp_pkg::t_state n_state;

    logic [gbp_pkg::MODE_W-1:0] r_mode;
    logic [INDEX_BITS-1:0]      r_hist;
    logic [INDEX_BITS-1:0]      n_hist;
    logic [INDEX_BITS-1:0]      r_clr_idx;
    logic [INDEX_BITS-1:0]      r_idx;
    logic [gbp_pkg::ADDR_W-1:0] r_addr;
    logic                       r_taken;
    logic                       r_out_valid;
    logic                       r_pred;
    logic                       r_conf;

    logic                       accept;
    logic                       lookup;
    logic [INDEX_BITS-1:0]      hash_idx;
    logic                       ram_we;
    logic [INDEX_BITS-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]         ram_wdata;
    logic [ENTRY_W-1:0]         ram_rdata;
    logic [gbp_pkg::CTR_W-1:0]  ctr_old;
    logic [gbp_pkg::CTR_W-1:0]  ctr_new;
    logic [gbp_pkg::ADDR_W-1:0] tag_old;

    gbp_index #(
        .INDEX_BITS (INDEX_BITS)
    ) u_index (
        .i_mode     (r_mode),
        .i_addr_low (i_branch_address[INDEX_BITS+1:0]),
        .i_history  (r_hist),
        .o_index    (hash_idx)
    );

    gbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (hash_idx),
        .o_rdata (ram_rdata)
    );

    assign o_ready = (r_state == gbp_pkg::ST_IDLE) && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;
    assign lookup  = (r_state == gbp_pkg::ST_LOOKUP);

    assign ctr_old = ram_rdata[gbp_pkg::CTR_W-1:0];
    assign tag_old = ram_rdata[ENTRY_W-1:gbp_pkg::CTR_W];

    always_comb begin
        ctr_new = ctr_old;
        if (r_taken) begin
            if (ctr_old != gbp_pkg::CTR_MAX) begin
                ctr_new = ctr_old + 2'd1;
            end
        end else begin
            if (ctr_old != gbp_pkg::CTR_MIN) begin
                ctr_new = ctr_old - 2'd1;
            end
        end
    end

    assign n_hist = (r_hist << 1) | INDEX_BITS'(r_taken);

    always_comb begin
        n_state   = r_state;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {r_addr, ctr_new};
        case (r_state)
            gbp_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = {{gbp_pkg::ADDR_W{1'b0}}, gbp_pkg::CTR_WEAK_NT};
                if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                    n_state = gbp_pkg::ST_IDLE;
                end
            end
            gbp_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = gbp_pkg::ST_LOOKUP;
                end
            end
            gbp_pkg::ST_LOOKUP: begin
                ram_we  = 1'b1;
                n_state = gbp_pkg::ST_IDLE;
            end
            default: begin
                n_state = gbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbp_pkg::ST_CLEAR;
            r_mode      <= gbp_pkg::HASH_XOR_SHIFT;
            r_hist      <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_state == gbp_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + INDEX_BITS'(1);
            end
            if (lookup) begin
                r_hist      <= n_hist;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx   <= hash_idx;
            r_addr  <= i_branch_address;
            r_taken <= i_actual_taken;
        end
        if (lookup) begin
            r_pred <= ctr_old[1];
            r_conf <= (tag_old != r_addr);
        end
    end

    assign o_valid           = r_out_valid;
    assign o_predicted_taken = r_pred;
    assign o_tag_conflict    = r_conf;

    `ASSERT_PROP(a_accept_to_lookup, i_clk, i_rst_n,
        accept |=> (r_state == gbp_pkg::ST_LOOKUP) && !r_out_valid)
    `ASSERT_PROP(a_result_from_lookup, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state) == gbp_pkg::ST_LOOKUP)
    `ASSERT_PROP(a_writeback_index, i_clk, i_rst_n,
        lookup |-> ram_we && (ram_waddr == r_idx))
    `ASSERT_NEVER(a_no_accept_in_clear, i_clk, i_rst_n,
        (r_state == gbp_pkg::ST_CLEAR) && (accept || r_out_valid))

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gshare branch predictor. Resolved branches are
// streamed through the valid/ready input while the result side stalls at
// random; a local copy of the history, the counter table and the address tags
// forecasts each prediction and tag conflict, which are checked in order.
// The run steps through every hash mode, including the unused code.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W     = gbp_pkg::ADDR_W;
    localparam int CTR_W      = gbp_pkg::CTR_W;
    localparam int MODE_W     = gbp_pkg::MODE_W;
    localparam int IDX_W      = 12;
    localparam int TBL_DEPTH  = 1 << IDX_W;
    localparam int HANG_LIMIT = 20000;
    localparam int HOT_PCS    = 16;

    localparam logic [MODE_W-1:0] HASH_SPARE = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic              taken;
    } t_branch;

    typedef struct packed {
        logic pred;
        logic conflict;
    } t_verdict;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [MODE_W-1:0] i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [ADDR_W-1:0] i_branch_address = '0;
    logic              i_actual_taken = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_predicted_taken;
    logic              o_tag_conflict;

    t_branch  branch_q[$];
    t_verdict verdict_q[$];

    logic [CTR_W-1:0]  ctr_tbl[TBL_DEPTH];
    logic [ADDR_W-1:0] tag_tbl[TBL_DEPTH];
    logic [IDX_W-1:0]  ghist = '0;
    logic [MODE_W-1:0] hash_sel = gbp_pkg::HASH_XOR_SHIFT;

    logic [ADDR_W-1:0] hot_pc[HOT_PCS];
    logic              hot_bias[HOT_PCS];

    t_branch  cur_branch;
    t_verdict want;
    int       send_gap = 0;
    int       stall_cnt = 0;
    int       hang_cnt = 0;
    int       err_cnt = 0;
    bit       calm = 1'b0;

    gshare_branch_predictor #(
        .INDEX_BITS(IDX_W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_branch_address (i_branch_address),
        .i_actual_taken   (i_actual_taken),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_predicted_taken(o_predicted_taken),
        .o_tag_conflict   (o_tag_conflict)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_verdict train_and_predict(input logic [ADDR_W-1:0] pc,
                                                   input logic taken);
        logic [ADDR_W-1:0] h;
        logic [IDX_W-1:0]  idx;
        logic [CTR_W-1:0]  ctr;
        t_verdict          v;
        case (hash_sel)
            gbp_pkg::HASH_XOR_SHIFT: h = (pc >> 2) ^ ADDR_W'(ghist);
            gbp_pkg::HASH_XOR_RAW:   h = pc ^ ADDR_W'(ghist);
            default:                 h = (pc >> 2) + ADDR_W'(ghist);
        endcase
        idx = h[IDX_W-1:0];
        ctr = ctr_tbl[idx];
        v.pred = (ctr > gbp_pkg::CTR_WEAK_NT);
        v.conflict = (tag_tbl[idx] != pc);
        if (taken) begin
            if (ctr != gbp_pkg::CTR_MAX) ctr = ctr + 2'd1;
        end else if (ctr != gbp_pkg::CTR_MIN) begin
            ctr = ctr - 2'd1;
        end
        ctr_tbl[idx] = ctr;
        tag_tbl[idx] = pc;
        ghist = {ghist[IDX_W-2:0], taken};
        return v;
    endfunction

    function automatic t_branch random_branch();
        t_branch b;
        int      pick;
        int      slot;
        pick = $urandom_range(0, 9);
        slot = $urandom_range(0, HOT_PCS - 1);
        if (pick < 7) begin
            b.pc = hot_pc[slot];
            b.taken = hot_bias[slot] ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
        end else begin
            case (pick)
                7:       b.pc = {$urandom, $urandom};
                8:       b.pc = ADDR_W'($urandom_range(0, 63));
                default: b.pc = {1'b1, 31'($urandom), 32'($urandom)};
            endcase
            b.taken = 1'($urandom_range(0, 1));
        end
        return b;
    endfunction

    task automatic push_branch(input logic [ADDR_W-1:0] pc, input logic taken);
        t_branch b;
        b.pc = pc;
        b.taken = taken;
        branch_q.push_back(b);
    endtask

    task automatic push_random(input int n);
        repeat (n) branch_q.push_back(random_branch());
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (branch_q.size() != 0 || i_valid || verdict_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_hash_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        hash_sel = m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic want_v, input logic got_v);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("Mismatch on %s: expected %0b, got %0b at %0t", what, want_v, got_v,
                     $realtime);
        end
    endtask

    initial begin
        foreach (ctr_tbl[i]) begin
            ctr_tbl[i] = gbp_pkg::CTR_WEAK_NT;
            tag_tbl[i] = '0;
        end
        foreach (hot_pc[i]) begin
            hot_pc[i] = {$urandom, $urandom};
            hot_bias[i] = 1'($urandom_range(0, 1));
        end
        hot_pc[0] = '0;
        hot_pc[1] = ADDR_W'($urandom_range(0, 4095)) << 2;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_branch('0, 1'b0);
        push_branch('0, 1'b0);
        push_branch('1, 1'b1);
        push_branch('1, 1'b0);
        push_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        push_branch(64'h5555_5555_5555_5555, 1'b0);
        push_branch(64'h8000_0000_0000_0000, 1'b1);
        repeat (14) push_branch(64'h0000_0000_0000_1000, 1'b1);
        repeat (3) push_branch(64'h0000_0000_0000_1000, 1'b0);
        push_random(60);

        set_hash_mode(gbp_pkg::HASH_XOR_RAW);
        push_random(90);
        set_hash_mode(gbp_pkg::HASH_ADD_SHIFT);
        push_branch('1, 1'b1);
        push_random(90);
        set_hash_mode(HASH_SPARE);
        push_random(60);
        set_hash_mode(gbp_pkg::HASH_XOR_SHIFT);
        push_random(90);

        wait_drained();
        calm = 1'b1;
        set_hash_mode(gbp_pkg::HASH_ADD_SHIFT);
        push_random(90);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || o_ready) begin
            if (send_gap != 0) begin
                i_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_valid <= 1'b0;
                send_gap <= $urandom_range(0, 17);
            end else if (branch_q.size() != 0) begin
                cur_branch = branch_q.pop_front();
                i_valid <= 1'b1;
                i_branch_address <= cur_branch.pc;
                i_actual_taken <= cur_branch.taken;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_cnt <= 0;
        end else if (stall_cnt != 0) begin
            i_ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            i_ready <= 1'b0;
            stall_cnt <= $urandom_range(0, 17);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (verdict_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("Unexpected result: predicted_taken %0b, %s %0b at %0t",
                                 o_predicted_taken, "tag_conflict", o_tag_conflict,
                                 $realtime);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (o_predicted_taken !== want.pred) begin
                        note_mismatch("predicted_taken", want.pred, o_predicted_taken);
                    end
                    if (o_tag_conflict !== want.conflict) begin
                        note_mismatch("tag_conflict", want.conflict, o_tag_conflict);
                    end
                end
            end
            if (i_valid && o_ready) begin
                verdict_q.push_back(train_and_predict(i_branch_address, i_actual_taken));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            hang_cnt <= 0;
        end else if (hang_cnt >= HANG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            hang_cnt <= hang_cnt + 1;
        end
    end

endmodule

`default_nettype wire
